// ===== rtl/dtsu_pkg.sv =====
package dtsu_pkg;

    // Fixed field widths of the stream items and the configuration register.
    localparam int NODE_W           = 5;
    localparam int NODE_COUNT_W     = 6;
    localparam int ID_LIMIT         = 32;
    localparam int MAX_NODES_DEFAULT = 32;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = NODE_COUNT_W'(32);

    // Input kind codes carried on the slave tuser.
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic edge_wr;     // store one dependency edge
        logic run_start;   // reset marks, counters and walk position
        logic walk_step;   // one push, pop or root skip of the walk
        logic walk_clear;  // wipe the edge store and the marks
        logic rd_issue;    // read the order buffer into its output register
        logic rd_advance;  // read the next entry instead of the current one
        logic out_load;    // present the read node as a result
        logic out_fail;    // present the single impossible result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_end;    // every root is done
        logic cycle_hit;   // the current step reaches a node on the path
        logic out_taken;   // the result transaction completes this cycle
        logic out_last;    // the held result closes the run
    } sts_t;

endpackage

// ===== rtl/dependency_topological_sort_unit.sv =====
// Dependency topological sort unit.
// The slave stream carries two kinds of transactions, told apart by s_tuser.
// An edge transaction (s_tuser = 0) stores "course_id needs prereq_id" in a
// bit matrix, and the unit is ready again on the next cycle. A run
// transaction (s_tuser = 1) starts a depth-first walk in ascending node
// order. Each walk cycle pushes one node, pops one finished node into the
// order buffer, or skips a finished root. The order buffer is then read
// out one result at a time: the next result is loaded into the output
// register only once the receiver has taken the one before it.
// Results leave prerequisite first with m_tlast on the final one. When a
// node is met again while it is still on the walk path, the run gives one
// result with m_tuser set and m_tlast set instead. Every run clears the edge
// store. The slave side is held off (s_tready low) from the run transaction
// until its last result is taken; a stalled receiver simply holds the result
// in the output register. Reset clears the edge store and sets the node
// count to 32; cfg_wen writes the node count and is meant for idle periods.
module dependency_topological_sort_unit
#(
    parameter int MAX_NODES = dtsu_pkg::MAX_NODES_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [dtsu_pkg::NODE_COUNT_W-1:0] cfg_wdata,  // node_count
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,    // course_id[4:0], prereq_id[9:5]
    input  logic                              s_tuser,    // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,    // node_id[4:0]
    output logic                              m_tuser,    // impossible
    output logic                              m_tlast
);

    dtsu_pkg::cmd_t               cmd;
    dtsu_pkg::sts_t               sts;
    logic [dtsu_pkg::NODE_W-1:0]  node_id;

    // The controller sequences edge loads, the walk and the read-out.
    dtsu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the edge matrix, marks, walk stack and order buffer.
    dtsu_dp
    #(
        .MAX_NODES (MAX_NODES)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .course_id  (s_tdata[4:0]),
        .prereq_id  (s_tdata[9:5]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .node_id    (node_id),
        .impossible (m_tuser),
        .last       (m_tlast)
    );

    assign m_tdata = {3'b000, node_id};

endmodule

// ===== rtl/dtsu_ctrl.sv =====
module dtsu_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_kind,
    output logic          s_tready,
    input  dtsu_pkg::sts_t sts,
    output dtsu_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_kind == dtsu_pkg::KIND_RUN)
                    begin
                        cmd.run_start = 1'b1;
                        state_next    = ST_WALK;
                    end
                    else
                    begin
                        cmd.edge_wr = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                if (sts.cycle_hit)
                begin
                    cmd.walk_clear = 1'b1;
                    cmd.out_fail   = 1'b1;
                    state_next     = ST_HOLD;
                end
                else if (sts.walk_end)
                begin
                    cmd.walk_clear = 1'b1;
                    cmd.rd_issue   = 1'b1;
                    state_next     = ST_LOAD;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (sts.out_taken)
                begin
                    if (sts.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_issue   = 1'b1;
                        cmd.rd_advance = 1'b1;
                        state_next     = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/dtsu_dp.sv =====
module dtsu_dp
#(
    parameter int MAX_NODES = dtsu_pkg::MAX_NODES_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [dtsu_pkg::NODE_COUNT_W-1:0] cfg_wdata,
    input  logic [dtsu_pkg::NODE_W-1:0]       course_id,
    input  logic [dtsu_pkg::NODE_W-1:0]       prereq_id,
    input  dtsu_pkg::cmd_t                    cmd,
    output dtsu_pkg::sts_t                    sts,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [dtsu_pkg::NODE_W-1:0]       node_id,
    output logic                              impossible,
    output logic                              last
);

    localparam int LIM = (MAX_NODES < dtsu_pkg::ID_LIMIT) ? MAX_NODES : dtsu_pkg::ID_LIMIT;
    localparam int NW  = $clog2(LIM);
    localparam int CW  = $clog2(LIM + 1);

    logic [dtsu_pkg::NODE_COUNT_W-1:0] node_count_reg;
    logic [LIM-1:0]                    edge_reg [LIM];
    logic [LIM-1:0]                    done_reg;
    logic [LIM-1:0]                    path_reg;
    logic [NW-1:0]                     stack_reg [LIM];
    logic [NW-1:0]                     order_mem [LIM];
    logic [CW-1:0]                     depth_reg;
    logic [CW-1:0]                     root_reg;
    logic [CW-1:0]                     count_reg;
    logic [NW-1:0]                     rd_idx_reg;
    logic [NW-1:0]                     rdata_reg;
    logic                              out_valid_reg;
    logic [NW-1:0]                     out_node_reg;
    logic                              out_imp_reg;
    logic                              out_last_reg;

    logic [CW-1:0] n_eff;
    logic [LIM-1:0] mask;
    logic [CW-1:0] depth_m1;
    logic [NW-1:0] top_node;
    logic [LIM-1:0] pend;
    logic [NW-1:0] pick;
    logic          found;
    logic          at_root;
    logic          root_done;
    logic          do_skip;
    logic          do_push;
    logic          do_pop;
    logic [NW-1:0] push_node;
    logic          edge_ok;
    logic [NW-1:0] rd_addr;

    // Effective node count: zero acts as one, large values saturate.
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if ({1'b0, node_count_reg} > (dtsu_pkg::NODE_COUNT_W + 1)'(LIM))
        begin
            n_eff = CW'(LIM);
        end
        else
        begin
            n_eff = CW'(node_count_reg);
        end
        for (int i = 0; i < LIM; i++)
        begin
            mask[i] = (CW'(i) < n_eff);
        end
    end

    assign depth_m1  = depth_reg - CW'(1);
    assign top_node  = stack_reg[depth_m1[NW-1:0]];
    assign pend      = edge_reg[top_node] & mask & ~done_reg;
    assign at_root   = (depth_reg == '0);
    assign root_done = done_reg[root_reg[NW-1:0]];

    // Lowest pending prerequisite of the node on top of the stack.
    always_comb
    begin
        pick  = '0;
        found = 1'b0;
        for (int i = 0; i < LIM; i++)
        begin
            if (!found && pend[i])
            begin
                pick  = NW'(i);
                found = 1'b1;
            end
        end
    end

    assign sts.walk_end  = at_root && (root_reg >= n_eff);
    assign sts.cycle_hit = !at_root && found && path_reg[pick];
    assign sts.out_taken = out_valid_reg && m_tready;
    assign sts.out_last  = out_last_reg;

    assign do_skip   = cmd.walk_step && at_root && root_done;
    assign do_push   = cmd.walk_step && (at_root ? !root_done : found);
    assign do_pop    = cmd.walk_step && !at_root && !found;
    assign push_node = at_root ? root_reg[NW-1:0] : pick;

    assign edge_ok = ({1'b0, course_id} < (dtsu_pkg::NODE_W + 1)'(LIM))
                  && ({1'b0, prereq_id} < (dtsu_pkg::NODE_W + 1)'(LIM));

    assign rd_addr = cmd.rd_advance ? (rd_idx_reg + NW'(1)) : rd_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= dtsu_pkg::NODE_COUNT_RESET;
            for (int i = 0; i < LIM; i++)
            begin
                edge_reg[i] <= '0;
            end
            done_reg      <= '0;
            path_reg      <= '0;
            depth_reg     <= '0;
            root_reg      <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (cmd.edge_wr && edge_ok)
            begin
                edge_reg[course_id[NW-1:0]][prereq_id[NW-1:0]] <= 1'b1;
            end
            if (cmd.run_start)
            begin
                done_reg   <= '0;
                path_reg   <= '0;
                depth_reg  <= '0;
                root_reg   <= '0;
                count_reg  <= '0;
                rd_idx_reg <= '0;
            end
            if (do_skip)
            begin
                root_reg <= root_reg + CW'(1);
            end
            if (do_push)
            begin
                depth_reg           <= depth_reg + CW'(1);
                path_reg[push_node] <= 1'b1;
            end
            if (do_pop)
            begin
                depth_reg          <= depth_m1;
                path_reg[top_node] <= 1'b0;
                done_reg[top_node] <= 1'b1;
                count_reg          <= count_reg + CW'(1);
            end
            if (cmd.walk_clear)
            begin
                for (int i = 0; i < LIM; i++)
                begin
                    edge_reg[i] <= '0;
                end
                done_reg <= '0;
                path_reg <= '0;
            end
            if (cmd.rd_issue)
            begin
                rd_idx_reg <= rd_addr;
            end
            if (cmd.out_load || cmd.out_fail)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sts.out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk stack, order buffer and result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_reg[depth_reg[NW-1:0]] <= push_node;
        end
        if (do_pop)
        begin
            order_mem[count_reg[NW-1:0]] <= top_node;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= order_mem[rd_addr];
        end
        if (cmd.out_load)
        begin
            out_node_reg <= rdata_reg;
            out_imp_reg  <= 1'b0;
            out_last_reg <= ((CW'(rd_idx_reg) + CW'(1)) == count_reg);
        end
        else if (cmd.out_fail)
        begin
            out_node_reg <= '0;
            out_imp_reg  <= 1'b1;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign node_id    = dtsu_pkg::NODE_W'(out_node_reg);
    assign impossible = out_imp_reg;
    assign last       = out_last_reg;

endmodule

// ===== tb/tb_top.sv =====
// Block-level testbench for dependency_topological_sort_unit.
//
// The sender process feeds edge and run transactions on the slave stream. When
// a run transaction is accepted, a behavioral model of the depth-first sort
// computes the node order, or the single impossible result. That prediction is
// queued. A checker on the master stream compares every accepted result
// transaction field by field with the oldest queued entry.
module tb_top;

    localparam int HALF_PERIOD    = 10;
    localparam int RANDOM_ITEMS   = 345;
    localparam int SETTLE_CYCLES  = 8;     // idle gap before a node count write
    localparam int HOLD_CYCLES    = 400;   // one long receiver back-pressure episode
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transaction
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_ROWS  = 21;

    // One result transaction as the checker sees it.
    typedef struct packed {
        logic [dtsu_pkg::NODE_W-1:0] node;
        logic                        impossible;
        logic                        last;
    } order_item_t;

    // One row of the directed stimulus. When set_count is high, the node count is
    // written before the transaction is sent. When typed is high, the row carries
    // its own single-result expectation and does not use the model's output.
    typedef struct packed {
        logic                              set_count;
        logic [dtsu_pkg::NODE_COUNT_W-1:0] count_val;
        logic                              kind;
        logic [dtsu_pkg::NODE_W-1:0]       course;
        logic [dtsu_pkg::NODE_W-1:0]       prereq;
        logic                              typed;
        order_item_t                       typed_result;
    } dir_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_wen;
    logic [dtsu_pkg::NODE_COUNT_W-1:0] cfg_wdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [15:0]                       s_tdata;   // course_id[4:0], prereq_id[9:5]
    logic                              s_tuser;   // kind
    logic                              m_tvalid;
    logic                              m_tready;
    logic [7:0]                        m_tdata;   // node_id[4:0]
    logic                              m_tuser;   // impossible
    logic                              m_tlast;

    // Model state. Row c, bit p means that node c needs node p first.
    logic [31:0]                       needs_rows [32];
    logic [dtsu_pkg::NODE_COUNT_W-1:0] node_count_model;

    order_item_t expected_order [$];
    order_item_t run_results [$];
    order_item_t head_item;

    int  items_sent;
    int  results_taken;
    int  mismatches;
    int  quiet_cycles;
    bit  hold_asked;

    // Directed stimulus. It covers the extremes of every field, each node count
    // corner case, two-node loops, self loops, repeated edges, and edges that lie
    // past the node count.
    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        // With the reset count and no edges, the unit lists all 32 nodes in order.
        '{1'b0, 6'd0,  dtsu_pkg::KIND_RUN,  5'd0,  5'd0,  1'b0, '{5'd0, 1'b0, 1'b0}},
        // A loop between node 0 and node 31 makes any order impossible.
        '{1'b0, 6'd0,  dtsu_pkg::KIND_EDGE, 5'd31, 5'd0,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_EDGE, 5'd0,  5'd31, 1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_RUN,  5'd0,  5'd0,  1'b1, '{5'd0, 1'b1, 1'b1}},
        // A node that needs itself is also a loop.
        '{1'b0, 6'd0,  dtsu_pkg::KIND_EDGE, 5'd5,  5'd5,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_RUN,  5'd31, 5'd31, 1'b1, '{5'd0, 1'b1, 1'b1}},
        // With a single node, edges that touch higher nodes are ignored.
        '{1'b1, 6'd1,  dtsu_pkg::KIND_EDGE, 5'd0,  5'd1,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_EDGE, 5'd3,  5'd3,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_RUN,  5'd0,  5'd0,  1'b1, '{5'd0, 1'b0, 1'b1}},
        // A count of zero behaves like a count of one.
        '{1'b1, 6'd0,  dtsu_pkg::KIND_RUN,  5'd0,  5'd0,  1'b1, '{5'd0, 1'b0, 1'b1}},
        // A count above 32 is clamped. The chain includes one edge given twice.
        '{1'b1, 6'd63, dtsu_pkg::KIND_EDGE, 5'd1,  5'd2,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_EDGE, 5'd2,  5'd3,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_EDGE, 5'd1,  5'd2,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_EDGE, 5'd30, 5'd31, 1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_EDGE, 5'd31, 5'd1,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_RUN,  5'd0,  5'd0,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b1, 6'd2,  dtsu_pkg::KIND_EDGE, 5'd0,  5'd1,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_RUN,  5'd0,  5'd0,  1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b1, 6'd32, dtsu_pkg::KIND_EDGE, 5'd10, 5'd21, 1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_EDGE, 5'd21, 5'd20, 1'b0, '{5'd0, 1'b0, 1'b0}},
        '{1'b0, 6'd0,  dtsu_pkg::KIND_RUN,  5'd0,  5'd0,  1'b0, '{5'd0, 1'b0, 1'b0}}
    };

    dependency_topological_sort_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // Returns the number of nodes that a run actually walks. Zero is treated as
    // one, and anything above 32 is clamped to 32.
    function automatic int active_nodes();
        int lim;
        int n;
        lim = (dtsu_pkg::MAX_NODES_DEFAULT < dtsu_pkg::ID_LIMIT) ?
              dtsu_pkg::MAX_NODES_DEFAULT : dtsu_pkg::ID_LIMIT;
        n = int'(node_count_model);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > lim)
        begin
            n = lim;
        end
        return n;
    endfunction

    // Performs the depth-first, post-order walk for one run and fills
    // run_results. Roots and children are taken in ascending order. If the walk
    // steps onto a node that is still on the current path, a loop exists and the
    // run gives one impossible result. Every run clears the edge store.
    function automatic void sort_nodes();
        int                          n;
        int                          depth;
        int                          v;
        int                          j;
        bit                          loop_found;
        logic [31:0]                 mask;
        logic [31:0]                 done_m;
        logic [31:0]                 path_m;
        logic [31:0]                 pend;
        logic [dtsu_pkg::NODE_W-1:0] stack [32];
        order_item_t                 r;
        run_results.delete();
        n = active_nodes();
        mask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        done_m = '0;
        path_m = '0;
        loop_found = 1'b0;
        for (int root = 0; root < n && !loop_found; root++)
        begin
            if (!done_m[root])
            begin
                stack[0] = dtsu_pkg::NODE_W'(root);
                depth = 1;
                path_m[root] = 1'b1;
                while (depth > 0 && !loop_found)
                begin
                    v = int'(stack[depth - 1]);
                    pend = needs_rows[v] & mask & ~done_m;
                    if (pend != '0)
                    begin
                        j = 0;
                        while (!pend[j])
                        begin
                            j++;
                        end
                        if (path_m[j])
                        begin
                            loop_found = 1'b1;
                        end
                        else
                        begin
                            stack[depth] = dtsu_pkg::NODE_W'(j);
                            depth++;
                            path_m[j] = 1'b1;
                        end
                    end
                    else
                    begin
                        depth--;
                        path_m[v] = 1'b0;
                        done_m[v] = 1'b1;
                        r.node = dtsu_pkg::NODE_W'(v);
                        r.impossible = 1'b0;
                        r.last = 1'b0;
                        run_results = {run_results, r};
                    end
                end
            end
        end
        if (loop_found)
        begin
            run_results.delete();
            r.node = '0;
            r.impossible = 1'b1;
            r.last = 1'b1;
            run_results = {run_results, r};
        end
        else if (run_results.size() > 0)
        begin
            run_results[run_results.size() - 1].last = 1'b1;
        end
        for (int i = 0; i < 32; i++)
        begin
            needs_rows[i] = '0;
        end
    endfunction

    // Offers one slave transaction, starting and ending at a falling edge. Random
    // idle cycles come before the offer, except within a burst window where the
    // sender drives back to back. s_tvalid is not lowered at the end, so
    // consecutive transactions do not assign it twice in the same time step.
    task automatic send_item(input logic kind, input logic [dtsu_pkg::NODE_W-1:0] course,
                             input logic [dtsu_pkg::NODE_W-1:0] prereq, input logic typed,
                             input order_item_t typed_result);
        while (!(items_sent >= 150 && items_sent < 230) && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'b0, prereq, course};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (kind == dtsu_pkg::KIND_EDGE)
        begin
            needs_rows[course][prereq] = 1'b1;
        end
        else
        begin
            sort_nodes();
            if (typed)
            begin
                expected_order = {expected_order, typed_result};
            end
            else
            begin
                foreach (run_results[i])
                begin
                    expected_order = {expected_order, run_results[i]};
                end
            end
        end
        @(negedge clk);
    endtask

    // Waits, with the sender idle, until every predicted result has arrived. It
    // then waits a short settle time so that the unit is fully idle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_order.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(input logic [dtsu_pkg::NODE_COUNT_W-1:0] val);
        drain_results();
        cfg_wen <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wen <= 1'b0;
        node_count_model = val;
    endtask

    // The first node count settings are the extremes. After that, most are
    // small counts, with occasional full and out-of-range values.
    function automatic logic [dtsu_pkg::NODE_COUNT_W-1:0] pick_count(input int phase);
        int r;
        case (phase)
            0: return dtsu_pkg::NODE_COUNT_W'(1);
            1: return dtsu_pkg::NODE_COUNT_W'(32);
            2: return dtsu_pkg::NODE_COUNT_W'(0);
            3: return dtsu_pkg::NODE_COUNT_W'(63);
            default:
            begin
                r = $urandom_range(99);
                if (r < 60)
                begin
                    return dtsu_pkg::NODE_COUNT_W'($urandom_range(8, 2));
                end
                else if (r < 75)
                begin
                    return dtsu_pkg::NODE_COUNT_W'($urandom_range(31, 9));
                end
                else if (r < 85)
                begin
                    return dtsu_pkg::NODE_COUNT_W'(32);
                end
                return dtsu_pkg::NODE_COUNT_W'($urandom_range(63, 0));
            end
        endcase
    endfunction

    // Builds one random dependency graph and closes it with a run transaction.
    // Most graphs are acyclic: nodes are given a random rank, and every edge
    // points from a higher rank to a lower one. The rest add a reversed edge that
    // may close a loop, a self loop, random noise across all 32 ids, or repeated
    // edges and edges past the node count.
    task automatic build_graph(input bit hold_results);
        int                          n;
        int                          style;
        int                          edges;
        int                          a;
        int                          b;
        int                          t;
        int                          rank [32];
        logic [dtsu_pkg::NODE_W-1:0] course;
        logic [dtsu_pkg::NODE_W-1:0] prereq;
        n = active_nodes();
        for (int i = 0; i < 32; i++)
        begin
            rank[i] = i;
        end
        for (int i = n - 1; i > 0; i--)
        begin
            a = $urandom_range(i, 0);
            t = rank[i];
            rank[i] = rank[a];
            rank[a] = t;
        end
        style = $urandom_range(99);
        edges = (n < 2) ? 0 : $urandom_range((n < 6) ? n : 10, 0);
        course = '0;
        prereq = '0;
        for (int k = 0; k < edges; k++)
        begin
            a = $urandom_range(n - 1, 0);
            b = (a + 1 + $urandom_range(n - 2, 0)) % n;
            if (rank[a] < rank[b])
            begin
                t = a;
                a = b;
                b = t;
            end
            course = dtsu_pkg::NODE_W'(a);
            prereq = dtsu_pkg::NODE_W'(b);
            send_item(dtsu_pkg::KIND_EDGE, course, prereq, 1'b0, '0);
        end
        if (style >= 65 && style < 72)
        begin
            a = $urandom_range(n - 1, 0);
            send_item(dtsu_pkg::KIND_EDGE, dtsu_pkg::NODE_W'(a), dtsu_pkg::NODE_W'(a),
                      1'b0, '0);
        end
        else if (style >= 72 && style < 80 && n >= 2)
        begin
            // This edge goes against the rank order. It closes a loop only when
            // a path in the other direction already exists.
            a = $urandom_range(n - 1, 0);
            b = (a + 1 + $urandom_range(n - 2, 0)) % n;
            if (rank[a] > rank[b])
            begin
                t = a;
                a = b;
                b = t;
            end
            send_item(dtsu_pkg::KIND_EDGE, dtsu_pkg::NODE_W'(a), dtsu_pkg::NODE_W'(b),
                      1'b0, '0);
        end
        else if (style >= 80 && style < 90)
        begin
            repeat ($urandom_range(4, 1))
            begin
                send_item(dtsu_pkg::KIND_EDGE, dtsu_pkg::NODE_W'($urandom_range(31, 0)),
                          dtsu_pkg::NODE_W'($urandom_range(31, 0)), 1'b0, '0);
            end
        end
        else if (style >= 90)
        begin
            if (edges > 0)
            begin
                send_item(dtsu_pkg::KIND_EDGE, course, prereq, 1'b0, '0);
            end
            if (n < 32)
            begin
                send_item(dtsu_pkg::KIND_EDGE, dtsu_pkg::NODE_W'($urandom_range(31, n)),
                          dtsu_pkg::NODE_W'($urandom_range(31, 0)), 1'b0, '0);
            end
        end
        if (hold_results)
        begin
            hold_asked = 1'b1;
        end
        // The id fields of a run transaction are don't-care, so they carry noise.
        send_item(dtsu_pkg::KIND_RUN, dtsu_pkg::NODE_W'($urandom_range(31, 0)),
                  dtsu_pkg::NODE_W'($urandom_range(31, 0)), 1'b0, '0);
    endtask

    // Result checker. Sampling is on the rising edge. Inputs only change on the
    // falling edge, so there is no race with the unit's own registers.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_taken++;
            if (expected_order.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                begin
                    $display("Unexpected result: m_tdata %0h m_tuser %0b m_tlast %0b",
                             m_tdata, m_tuser, m_tlast);
                end
                mismatches++;
            end
            else
            begin
                head_item = expected_order.pop_front();
                if (m_tdata !== {3'b0, head_item.node} || m_tuser !== head_item.impossible
                    || m_tlast !== head_item.last)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("Result mismatch: expected node %0d impossible %0b last %0b,",
                                 head_item.node, head_item.impossible, head_item.last);
                        $display("    got m_tdata %0h m_tuser %0b m_tlast %0b",
                                 m_tdata, m_tuser, m_tlast);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog. It counts consecutive cycles in which no transaction is accepted
    // on either stream.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver. It stalls at random about 15 percent of the time, except while
    // the results from number 200 to number 400 are coming, when it is always
    // ready. Once, when the sender asks for it, it holds m_tready low for a long
    // stretch. This makes the unit back up and stall its slave side while the
    // sender keeps offering transactions.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_asked)
            begin
                hold_asked = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (results_taken >= 200 && results_taken < 400)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= 15);
            end
        end
    end

    // Main stimulus. It runs reset, then the directed rows, then random graphs.
    // The node count changes every fifth graph. Graph 12 waits for every
    // result to arrive before it starts.
    initial
    begin
        int graph_no;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = dtsu_pkg::KIND_EDGE;
        items_sent = 0;
        results_taken = 0;
        mismatches = 0;
        quiet_cycles = 0;
        hold_asked = 1'b0;
        node_count_model = dtsu_pkg::NODE_COUNT_RESET;
        for (int i = 0; i < 32; i++)
        begin
            needs_rows[i] = '0;
        end
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_count)
            begin
                write_count(directed_rows[i].count_val);
            end
            send_item(directed_rows[i].kind, directed_rows[i].course,
                      directed_rows[i].prereq, directed_rows[i].typed,
                      directed_rows[i].typed_result);
        end

        graph_no = 0;
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            if (graph_no % 5 == 0)
            begin
                write_count(pick_count(graph_no / 5));
            end
            else if (graph_no == 12)
            begin
                drain_results();
            end
            build_graph(graph_no == 7);
            graph_no++;
        end

        drain_results();
        if (mismatches == 0 && expected_order.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
